[rtl/dmnc_pkg.sv]
// Shared types, constants and codes of the direct-mapped name cache.
package dmnc_pkg;

  localparam int INO_W = 64;
  localparam int HASH_W = 64;
  localparam int LEN_W = 8;
  localparam int MIX_W = 64;
  localparam int REQ_W = 2;

  localparam int DMNC_DEPTH = 4096;

  // Slot index mixing constants.
  localparam int LEN_MULT_W = 24;
  localparam logic [LEN_MULT_W-1:0] LEN_MULT = LEN_MULT_W'(8648737);
  localparam int LEN_ROT = 19;
  localparam int PROD_W = LEN_W + LEN_MULT_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_REMAP  = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef struct packed {
    logic [INO_W-1:0]  parent;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
    logic [INO_W-1:0]  target;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_CMP,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_start;
    logic ram_we;
    logic sel_sweep;
    logic sweep_clr;
    logic sweep_inc;
    logic capture;
    logic out_load;
  } dmnc_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             usable;
    logic             mod_done;
    logic             sweep_last;
  } dmnc_sts_t;

endpackage

[rtl/dmnc_in_if.sv]
// Request channel of the name cache.
interface dmnc_in_if import dmnc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [INO_W-1:0]  parent_ino;
  logic [HASH_W-1:0] name_hash;
  logic [LEN_W-1:0]  name_len;
  logic [INO_W-1:0]  target_ino;

  modport source (
    output valid, req_type, parent_ino, name_hash, name_len, target_ino,
    input  ready
  );
  modport sink (
    input  valid, req_type, parent_ino, name_hash, name_len, target_ino,
    output ready
  );
endinterface

[rtl/dmnc_out_if.sv]
// Result channel of the name cache.
interface dmnc_out_if import dmnc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [INO_W-1:0] found_ino;

  modport source (
    output valid, hit, found_ino,
    input  ready
  );
  modport sink (
    input  valid, hit, found_ino,
    output ready
  );
endinterface

[rtl/dmnc_ram.sv]
// Generic single-port RAM with registered read data.
module dmnc_ram import dmnc_pkg::*; #(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = DMNC_DEPTH,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/dmnc_mod.sv]
// Reduces the 64-bit slot mix to a table index, modulo the table depth.
module dmnc_mod import dmnc_pkg::*; #(
  parameter int TABLE_DEPTH = DMNC_DEPTH,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MIX_W-1:0] mix,
  output logic             done,
  output logic [IDX_W-1:0] idx
);

  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int BYTE_W = 8;
  localparam int NB = MIX_W / BYTE_W;

  logic             done_r;
  logic [IDX_W-1:0] rem_r;

  // Residue of two to the power BYTE_W * pos, modulo the depth.
  function automatic logic [IDX_W-1:0] byte_res(input int pos);
    longint r;
    r = 1;
    for (int j = 0; j < pos; j++) begin
      r = (r * (longint'(1) << BYTE_W)) % TABLE_DEPTH;
    end
    return IDX_W'(r);
  endfunction

  generate
    if (IS_POW2) begin : g_mask
      // A power-of-two depth keeps the low bits.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          rem_r <= mix[IDX_W-1:0];
        end
      end
    end else begin : g_fold
      localparam int SUM_W = IDX_W + BYTE_W + $clog2(NB);
      localparam int QUO_W = SUM_W - IDX_W + 1;
      localparam int FULL_W = 2 * SUM_W + 1;
      localparam int RECIP_SH = SUM_W + IDX_W;
      localparam logic [SUM_W:0] RECIP =
        (SUM_W + 1)'((64'd1 << RECIP_SH) / 64'(TABLE_DEPTH));
      localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(TABLE_DEPTH);

      logic              v1_r;
      logic              v2_r;
      logic [SUM_W-1:0]  term [NB];
      logic [SUM_W-1:0]  sum;
      logic [SUM_W-1:0]  sum_r;
      logic [FULL_W-1:0] full;
      logic [QUO_W-1:0]  quo_r;
      logic [IDX_W:0]    quo_d;
      logic [IDX_W:0]    diff;
      logic [IDX_W-1:0]  rem_nxt;

      // Each byte is weighted by its place value modulo the depth, which
      // leaves a short word with the same residue.
      for (genvar i = 0; i < NB; i++) begin : g_term
        localparam logic [IDX_W-1:0] RES = byte_res(i);
        assign term[i] = SUM_W'(mix[BYTE_W*i +: BYTE_W]) * SUM_W'(RES);
      end

      always_comb begin
        sum = '0;
        for (int i = 0; i < NB; i++) begin
          sum = sum + term[i];
        end
      end

      // The reciprocal quotient is never above the true one and at most one
      // below it, so one conditional subtract finishes the remainder.
      assign full    = FULL_W'(sum_r) * FULL_W'(RECIP);
      assign quo_d   = (IDX_W + 1)'(quo_r) * DEPTH_W;
      assign diff    = sum_r[IDX_W:0] - quo_d;
      assign rem_nxt = (diff >= DEPTH_W) ? IDX_W'(diff - DEPTH_W) : diff[IDX_W-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r   <= 1'b0;
          v2_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          v1_r   <= start;
          v2_r   <= v1_r;
          done_r <= v2_r;
        end
        if (start) begin
          sum_r <= sum;
        end
        if (v1_r) begin
          quo_r <= full[FULL_W-1 -: QUO_W];
        end
        if (v2_r) begin
          rem_r <= rem_nxt;
        end
      end
    end
  endgenerate

  assign done = done_r;
  assign idx  = rem_r;

endmodule

[rtl/dmnc_dp.sv]
// Datapath: request registers, index mixing, slot store, compare and result.
module dmnc_dp import dmnc_pkg::*; #(
  parameter int TABLE_DEPTH = DMNC_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dmnc_cmd_t         cmd,
  output dmnc_sts_t         sts,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [INO_W-1:0]  in_parent_ino,
  input  logic [HASH_W-1:0] in_name_hash,
  input  logic [LEN_W-1:0]  in_name_len,
  input  logic [INO_W-1:0]  in_target_ino,
  output logic              out_hit,
  output logic [INO_W-1:0]  out_found_ino
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic [REQ_W-1:0]  req_type_r;
  logic [INO_W-1:0]  parent_r;
  logic [HASH_W-1:0] hash_r;
  logic [LEN_W-1:0]  len_r;
  logic [INO_W-1:0]  target_r;

  logic [IDX_W-1:0]  sweep_r;
  logic              res_hit_r;
  logic [INO_W-1:0]  res_ino_r;
  logic              out_hit_r;
  logic [INO_W-1:0]  out_ino_r;

  logic [PROD_W-1:0] prod;
  logic [MIX_W-1:0]  prod_ext;
  logic [MIX_W-1:0]  mix;
  logic              mod_done;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  ram_addr;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic              match;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      parent_r   <= in_parent_ino;
      hash_r     <= in_name_hash;
      len_r      <= in_name_len;
      target_r   <= in_target_ino;
    end
  end

  // The length term is rotated left by LEN_ROT inside a 64-bit word.
  assign prod     = PROD_W'(len_r) * PROD_W'(LEN_MULT);
  assign prod_ext = MIX_W'(prod);
  assign mix      = hash_r ^ ~parent_r ^
                    {prod_ext[MIX_W-1-LEN_ROT:0], prod_ext[MIX_W-1 -: LEN_ROT]};

  dmnc_mod #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .mix   (mix),
    .done  (mod_done),
    .idx   (idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_clr) begin
      sweep_r <= '0;
    end else if (cmd.sweep_inc) begin
      sweep_r <= sweep_r + 1'b1;
    end
  end

  // A sweep writes all-zero entries; a zero target marks the slot invalid.
  always_comb begin
    wr_entry.parent = parent_r;
    wr_entry.hash   = hash_r;
    wr_entry.len    = len_r;
    wr_entry.target = target_r;
    if (cmd.sel_sweep) begin
      wr_entry = '0;
    end
  end

  assign ram_addr = cmd.sel_sweep ? sweep_r : idx;

  dmnc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  assign match = (rd_entry.target != '0) && (rd_entry.hash == hash_r) &&
                 (rd_entry.parent == parent_r) && (rd_entry.len == len_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_hit_r <= 1'b0;
      res_ino_r <= '0;
    end else if (cmd.capture) begin
      res_hit_r <= match;
      res_ino_r <= match ? rd_entry.target : '0;
    end
    if (cmd.out_load) begin
      out_hit_r <= res_hit_r;
      out_ino_r <= res_ino_r;
    end
  end

  assign sts.req_type   = req_type_r;
  assign sts.usable     = (hash_r != '0) && (len_r != '0);
  assign sts.mod_done   = mod_done;
  assign sts.sweep_last = (sweep_r == IDX_LAST);

  assign out_hit       = out_hit_r;
  assign out_found_ino = out_ino_r;

endmodule

[rtl/dmnc_ctrl.sv]
// Controller: request sequencing, table sweeps and the result handshake.
module dmnc_ctrl import dmnc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dmnc_sts_t sts,
  output dmnc_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == ST_IDLE);
    case (state_r)
      ST_INIT: begin
        cmd.ram_we    = 1'b1;
        cmd.sel_sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.sweep_clr = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        case (sts.req_type)
          REQ_CLEAR: begin
            state_nxt = ST_CLEAR;
          end
          REQ_REMAP, REQ_LOOKUP: begin
            if (sts.usable) begin
              cmd.mod_start = 1'b1;
              state_nxt     = ST_MOD;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_MOD: begin
        // The index is ready once mod_done is set; a lookup's read is issued in that cycle.
        if (sts.mod_done) begin
          if (sts.req_type == REQ_REMAP) begin
            cmd.ram_we = 1'b1;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        cmd.capture = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.ram_we    = 1'b1;
        cmd.sel_sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.sweep_clr = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/direct_mapped_name_cache_unit.sv]
// Direct-mapped name cache: one result beat per request beat, in order.
// Each slot holds a parent inode, name hash, name length and target inode,
// indexed by the mixed key modulo TABLE_DEPTH; a zero target means empty.
// Requests are handled one at a time, and a new request is taken while the
// previous result beat still waits on the output register. With a
// power-of-two depth the index is the low bits of the mix; any other depth
// lengthens the index step, as the modulo unit folds the word byte by byte
// and then reduces it with a reciprocal multiplication. A clear, or a request
// with zero hash or zero length, skips the index step; a clear sweeps the
// whole slot RAM at one slot per cycle. After reset the same sweep runs over
// every slot before the first request beat is accepted.
module direct_mapped_name_cache_unit import dmnc_pkg::*; #(
  parameter int TABLE_DEPTH = DMNC_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  dmnc_in_if.sink    in_ch,
  dmnc_out_if.source out_ch
);

  dmnc_cmd_t cmd;
  dmnc_sts_t sts;

  dmnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmnc_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_ch.req_type),
    .in_parent_ino (in_ch.parent_ino),
    .in_name_hash  (in_ch.name_hash),
    .in_name_len   (in_ch.name_len),
    .in_target_ino (in_ch.target_ino),
    .out_hit       (out_ch.hit),
    .out_found_ino (out_ch.found_ino)
  );

endmodule

[rtl/dmnc_chk.sv]
// Port-level checker for the name cache, bound to the top level.
module dmnc_chk import dmnc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             hit,
  input logic [INO_W-1:0] found_ino
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pend_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Requests accepted whose result beat has not gone out yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(found_ino))
    else $error("result beat changed while stalled");

  a_hit_ino: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (hit == (found_ino != '0)))
    else $error("hit flag disagrees with found inode");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result beat without a pending request");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2) |-> !in_ready)
    else $error("request accepted with two requests outstanding");

endmodule

bind direct_mapped_name_cache_unit dmnc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .hit       (out_ch.hit),
  .found_ino (out_ch.found_ino)
);

[tb/tb_direct_mapped_name_cache_unit.sv]
// Self-checking testbench of the direct-mapped name cache unit.
`timescale 1ns / 100ps

module tb_direct_mapped_name_cache_unit;
  import dmnc_pkg::*;

  localparam int DEPTH = DMNC_DEPTH;
  localparam logic [63:0] KEY_LEN_MULT = 64'd8648737;
  localparam int KEY_LEN_ROT = 19;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [INO_W-1:0]  parent;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
  } name_key_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    name_key_t        key;
    logic [INO_W-1:0] target;
    logic             calm;
  } cache_req_t;

  typedef struct packed {
    logic             hit;
    logic [INO_W-1:0] found;
  } cache_reply_t;

  logic clk;
  logic rst_n;

  dmnc_in_if  in_ch ();
  dmnc_out_if out_ch ();

  direct_mapped_name_cache_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cache_req_t   request_q[$];
  cache_reply_t reply_q[$];
  name_key_t    known_keys[$];

  // Shadow copy of the slot table.
  logic [INO_W-1:0]  shadow_parent [DEPTH] = '{default: '0};
  logic [HASH_W-1:0] shadow_hash   [DEPTH] = '{default: '0};
  logic [LEN_W-1:0]  shadow_len    [DEPTH] = '{default: '0};
  logic [INO_W-1:0]  shadow_target [DEPTH] = '{default: '0};

  logic calm_now = 1'b0;
  int   err_count = 0;
  int   n_remap = 0;
  int   n_lookup = 0;
  int   n_clear = 0;
  int   n_unused = 0;
  int   n_hit = 0;

  function automatic int slot_of(name_key_t k);
    logic [63:0] prod;
    logic [63:0] spread;
    logic [63:0] mix;
    prod = 64'(k.len) * KEY_LEN_MULT;
    spread = (prod << KEY_LEN_ROT) | (prod >> (64 - KEY_LEN_ROT));
    mix = k.hash ^ ~k.parent ^ spread;
    return int'(mix % 64'(DEPTH));
  endfunction

  function automatic cache_reply_t predict_cache_reply(cache_req_t r);
    cache_reply_t rep;
    int           idx;
    logic         usable;
    rep = '0;
    usable = (r.key.hash != '0) && (r.key.len != '0);
    idx = slot_of(r.key);
    case (r.kind)
      REQ_REMAP: begin
        if (usable) begin
          shadow_parent[idx] = r.key.parent;
          shadow_hash[idx]   = r.key.hash;
          shadow_len[idx]    = r.key.len;
          shadow_target[idx] = r.target;
        end
      end
      REQ_LOOKUP: begin
        if (usable && shadow_target[idx] != '0 && shadow_parent[idx] == r.key.parent &&
            shadow_hash[idx] == r.key.hash && shadow_len[idx] == r.key.len) begin
          rep.hit = 1'b1;
          rep.found = shadow_target[idx];
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) shadow_target[i] = '0;
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic name_key_t fresh_key();
    name_key_t k;
    k.parent = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095)) : rand_word();
    k.hash = rand_word();
    k.len = LEN_W'($urandom_range(1, 255));
    return k;
  endfunction

  // Changes one key field while keeping the same slot, so the compare is exercised.
  // The length never reaches the low index bits after the rotate.
  function automatic name_key_t near_miss_key(name_key_t k);
    name_key_t m;
    m = k;
    case ($urandom_range(0, 2))
      0: m.parent = k.parent ^ (64'd1 << $urandom_range(12, 63));
      1: m.hash = k.hash ^ (64'd1 << $urandom_range(12, 63));
      default: m.len = LEN_W'(k.len + $urandom_range(1, 254));
    endcase
    return m;
  endfunction

  task automatic queue_request(input logic [REQ_W-1:0] kind, input name_key_t k,
                               input logic [INO_W-1:0] tgt, input logic calm);
    cache_req_t r;
    r.kind = kind;
    r.key = k;
    r.target = tgt;
    r.calm = calm;
    request_q.push_back(r);
    if (kind == REQ_REMAP && k.hash != '0 && k.len != '0) known_keys.push_back(k);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_direct_mapped_name_cache_unit NOT OK");
    $finish;
  end

  // Request driver: a beat stays on the bus until it is taken.
  always @(posedge clk) begin : drive_requests
    cache_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (request_q.size() != 0 && (request_q[0].calm || $urandom_range(0, 99) >= 8)) begin
        nxt = request_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= nxt.kind;
        in_ch.parent_ino <= nxt.key.parent;
        in_ch.name_hash  <= nxt.key.hash;
        in_ch.name_len   <= nxt.key.len;
        in_ch.target_ino <= nxt.target;
        calm_now         <= nxt.calm;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm_now || ($urandom_range(0, 99) >= 8);
    end
  end

  // Every accepted beat queues its reply; remaps and clears alter the shadow table.
  always @(posedge clk) begin : predict_on_accept
    cache_req_t   r;
    cache_reply_t rep;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r.kind = in_ch.req_type;
      r.key.parent = in_ch.parent_ino;
      r.key.hash = in_ch.name_hash;
      r.key.len = in_ch.name_len;
      r.target = in_ch.target_ino;
      r.calm = 1'b0;
      rep = predict_cache_reply(r);
      reply_q.push_back(rep);
      case (r.kind)
        REQ_REMAP:  n_remap++;
        REQ_LOOKUP: n_lookup++;
        REQ_CLEAR:  n_clear++;
        default:    n_unused++;
      endcase
      if (rep.hit) n_hit++;
    end
  end

  always @(posedge clk) begin : check_replies
    cache_reply_t exp_rep;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (reply_q.size() == 0) begin
        $error("reply beat with nothing outstanding: hit %0b found_ino %h",
               out_ch.hit, out_ch.found_ino);
        err_count++;
      end else begin
        exp_rep = reply_q.pop_front();
        if (out_ch.hit !== exp_rep.hit) begin
          $error("hit: expected %0b, got %0b", exp_rep.hit, out_ch.hit);
          err_count++;
        end
        if (out_ch.found_ino !== exp_rep.found) begin
          $error("found_ino: expected %h, got %h", exp_rep.found, out_ch.found_ino);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    name_key_t a;
    name_key_t b;
    name_key_t k;
    int        pick;
    logic      calm;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_REMAP;
    in_ch.parent_ino = '0;
    in_ch.name_hash = '0;
    in_ch.name_len = '0;
    in_ch.target_ino = '0;
    out_ch.ready = 1'b0;

    // Directed part: extremes, every request code and the skip cases.
    a = '{parent: '1, hash: '1, len: '1};
    b = '{parent: '0, hash: 64'd1, len: 8'd1};
    queue_request(REQ_LOOKUP, a, '0, 1'b0);
    queue_request(REQ_REMAP, a, '1, 1'b0);
    queue_request(REQ_LOOKUP, a, '0, 1'b0);
    queue_request(REQ_REMAP, b, 64'd1, 1'b0);
    queue_request(REQ_LOOKUP, b, '0, 1'b0);
    queue_request(REQ_LOOKUP, '{parent: 64'h8000_0000_0000_0000, hash: 64'd1, len: 8'd1},
                  '0, 1'b0);
    queue_request(REQ_LOOKUP, '{parent: '0, hash: 64'h0000_1000_0000_0001, len: 8'd1},
                  '0, 1'b0);
    queue_request(REQ_LOOKUP, '{parent: '0, hash: 64'd1, len: 8'd2}, '0, 1'b0);
    // A zero hash or a zero length must leave the slot alone.
    queue_request(REQ_REMAP, '{parent: '0, hash: '0, len: 8'd1}, 64'd7, 1'b0);
    queue_request(REQ_REMAP, '{parent: '0, hash: 64'd1, len: '0}, 64'd7, 1'b0);
    queue_request(REQ_LOOKUP, b, '0, 1'b0);
    queue_request(REQ_LOOKUP, '{parent: '0, hash: '0, len: 8'd1}, '0, 1'b0);
    queue_request(REQ_LOOKUP, '{parent: '0, hash: 64'd1, len: '0}, '0, 1'b0);
    // Remap with a zero target leaves the slot empty.
    queue_request(REQ_REMAP, b, '0, 1'b0);
    queue_request(REQ_LOOKUP, b, '0, 1'b0);
    queue_request(REQ_REMAP, b, 64'd5, 1'b0);
    queue_request(REQ_UNUSED, a, '1, 1'b0);
    queue_request(REQ_LOOKUP, b, '0, 1'b0);
    queue_request(REQ_CLEAR, a, '1, 1'b0);
    queue_request(REQ_LOOKUP, a, '0, 1'b0);
    queue_request(REQ_REMAP, a, 64'h5555_aaaa_5555_aaaa, 1'b0);
    // A second key in the same slot evicts the first.
    k = a;
    k.parent = a.parent ^ 64'h0000_0000_0010_0000;
    queue_request(REQ_REMAP, k, 64'haaaa_5555_aaaa_5555, 1'b0);
    queue_request(REQ_LOOKUP, a, '0, 1'b0);
    queue_request(REQ_LOOKUP, k, '0, 1'b0);

    // Random part: mostly well-formed remap and lookup traffic on live keys.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      calm = (i >= 200 && i < 350);
      if (pick < 33) begin
        k = ($urandom_range(0, 1) == 0) ? known_keys[$urandom_range(0, known_keys.size() - 1)]
                                        : fresh_key();
        queue_request(REQ_REMAP, k, ($urandom_range(0, 19) == 0) ? '0 : rand_word(), calm);
      end else if (pick < 80) begin
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        case ($urandom_range(0, 9))
          0, 1:    k = near_miss_key(k);
          2:       k = fresh_key();
          default: ;
        endcase
        queue_request(REQ_LOOKUP, k, rand_word(), calm);
      end else if (pick < 81) begin
        queue_request(REQ_CLEAR, fresh_key(), rand_word(), calm);
      end else if (pick < 83) begin
        queue_request(REQ_UNUSED, fresh_key(), rand_word(), calm);
      end else if (pick < 88) begin
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        if ($urandom_range(0, 1) == 0) k.hash = '0;
        else k.len = '0;
        queue_request($urandom_range(0, 1) ? REQ_LOOKUP : REQ_REMAP, k, rand_word(), calm);
      end else begin
        k = fresh_key();
        queue_request(REQ_REMAP, k, rand_word(), calm);
        queue_request(REQ_LOOKUP, k, rand_word(), calm);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (request_q.size() != 0 || in_ch.valid || reply_q.size() != 0);
    repeat (40) @(posedge clk);

    $display("Requests checked: %0d remaps, %0d lookups (%0d hits), %0d clears, %0d unused code.",
             n_remap, n_lookup, n_hit, n_clear, n_unused);
    if (err_count == 0) begin
      $display("tb_direct_mapped_name_cache_unit OK");
    end else begin
      $display("tb_direct_mapped_name_cache_unit NOT OK");
    end
    $finish;
  end

endmodule

[direct_mapped_name_cache_unit.f]
rtl/dmnc_pkg.sv
rtl/dmnc_in_if.sv
rtl/dmnc_out_if.sv
rtl/dmnc_ram.sv
rtl/dmnc_mod.sv
rtl/dmnc_dp.sv
rtl/dmnc_ctrl.sv
rtl/direct_mapped_name_cache_unit.sv
rtl/dmnc_chk.sv
tb/tb_direct_mapped_name_cache_unit.sv
